// File: src/stfc_pkg.sv
package stfc_pkg;

   localparam int TIMER_BITS = 16;

   localparam int ELAPSED_W = 16;
   localparam int SPEED_W   = 12;
   localparam int TDS_W     = 11;
   localparam int TURB_W    = 10;
   localparam int DIST_W    = 13;
   localparam int MOD_W     = 11;
   localparam int HOUR_W    = 5;
   localparam int MINUTE_W  = 6;
   localparam int BASE_W    = 16;
   localparam int HOLD_W    = 16;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_LEVEL   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_LEVEL  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_TDS_LIMIT   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_TURB_LIMIT  = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_FILL  = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_FILL = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME   = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_MINUTE = CSR_IDX_W'(7);

   localparam logic [DIST_W-1:0] LOW_LEVEL_RST   = DIST_W'(250);
   localparam logic [DIST_W-1:0] HIGH_LEVEL_RST  = DIST_W'(100);
   localparam logic [TDS_W-1:0]  TDS_LIMIT_RST   = TDS_W'(300);
   localparam logic [TURB_W-1:0] TURB_LIMIT_RST  = TURB_W'(280);
   localparam logic [MOD_W-1:0]  FIRST_FILL_RST  = MOD_W'(360);
   localparam logic [MOD_W-1:0]  SECOND_FILL_RST = MOD_W'(1080);
   localparam logic [HOLD_W-1:0] HOLD_TIME_RST   = HOLD_W'(2000);
   localparam logic [BASE_W-1:0] BASE_MINUTE_RST = BASE_W'(1000);

   localparam logic [HOUR_W-1:0]   HOUR_RST   = HOUR_W'(5);
   localparam logic [MINUTE_W-1:0] MINUTE_RST = MINUTE_W'(58);
   localparam logic [HOUR_W-1:0]   LAST_HOUR  = HOUR_W'(23);
   localparam logic [MINUTE_W-1:0] LAST_MINUTE = MINUTE_W'(59);
   localparam int MINUTES_PER_HOUR = 60;

   // interval = base * 4095 / (4095 + 59 * speed)
   localparam int SCALE_SHIFT = 12;
   localparam int SPEED_SCALE = (1 << SCALE_SHIFT) - 1;
   localparam int SPEED_SLOPE = 59;
   localparam int MIN_INTERVAL = 20;
   localparam int NUM_W = BASE_W + SCALE_SHIFT;
   localparam int DEN_W = 18;
   localparam int DIV_STEPS = NUM_W;
   localparam int STEP_W = $clog2(DIV_STEPS);

   localparam int ACC_W = ((TIMER_BITS > BASE_W) ? TIMER_BITS : BASE_W) + 1;
   localparam logic [ACC_W-1:0] TIMER_MAX = (ACC_W'(1) << TIMER_BITS) - ACC_W'(1);

   typedef struct packed {
      logic capture;
      logic div_step;
      logic commit;
   } stfc_cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } stfc_status_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_UPDATE = 3'b100
   } stfc_state_type;

endpackage

// File: src/scheduled_tank_fill_controller.sv
// Scheduled tank fill controller. Each req beat is one control cycle; it yields exactly one
// rsp beat with the scaled clock, water quality, fill, pump, hold and due-message state. An
// item is captured, then the restoring divider forms the minute interval one quotient bit per
// cycle, then the state is updated and the output register loaded. The next req beat is taken
// right after that update, while the previous rsp beat may still wait in the output register;
// if that register is still held by rsp_stall, the update waits. csr_ready is always high;
// registers are to be written between items by the user; the block does not enforce this.
module scheduled_tank_fill_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [stfc_pkg::ELAPSED_W-1:0]      req_elapsed_ms,
   input  logic [stfc_pkg::SPEED_W-1:0]        req_speed_reading,
   input  logic [stfc_pkg::TDS_W-1:0]          req_tds_ppm,
   input  logic [stfc_pkg::TURB_W-1:0]         req_turbidity_ntu,
   input  logic [stfc_pkg::DIST_W-1:0]         req_distance_mm,
   input  logic                                req_distance_valid,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [stfc_pkg::HOUR_W-1:0]         rsp_clock_hour,
   output logic [stfc_pkg::MINUTE_W-1:0]       rsp_clock_minute,
   output logic                                rsp_water_dirty,
   output logic                                rsp_fill_active,
   output logic                                rsp_pump_on,
   output logic                                rsp_hold_active,
   output logic                                rsp_due_message,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [stfc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [stfc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import stfc_pkg::*;

   stfc_cmd_type    cmd;
   stfc_status_type status;

   assign csr_ready = 1'b1;

   stfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   stfc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_elapsed_ms     (req_elapsed_ms),
      .req_speed_reading  (req_speed_reading),
      .req_tds_ppm        (req_tds_ppm),
      .req_turbidity_ntu  (req_turbidity_ntu),
      .req_distance_mm    (req_distance_mm),
      .req_distance_valid (req_distance_valid),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_clock_hour     (rsp_clock_hour),
      .rsp_clock_minute   (rsp_clock_minute),
      .rsp_water_dirty    (rsp_water_dirty),
      .rsp_fill_active    (rsp_fill_active),
      .rsp_pump_on        (rsp_pump_on),
      .rsp_hold_active    (rsp_hold_active),
      .rsp_due_message    (rsp_due_message)
   );

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed result not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit && rsp_valid && rsp_stall))
      else $error("stalled result overwritten");

   a_clock_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_clock_minute <= LAST_MINUTE && rsp_clock_hour <= LAST_HOUR))
      else $error("scaled clock out of range");

   a_pump_needs_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pump_on) |-> (rsp_fill_active && !rsp_water_dirty))
      else $error("pump on without clean pending fill");

endmodule

// File: src/stfc_div.sv
module stfc_div (
   input  logic                               clock,
   input  logic                               load,
   input  logic                               step,
   input  logic [stfc_pkg::NUM_W-1:0]         numerator,
   input  logic [stfc_pkg::DEN_W-1:0]         denominator,
   output logic [stfc_pkg::BASE_W-1:0]        quotient
);
   import stfc_pkg::*;

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] nq_ff, nq_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   // restoring division, one quotient bit per beat of step
   always_comb begin
      trial  = {rem_ff, nq_ff[NUM_W-1]};
      fits   = trial >= {1'b0, den_ff};
      rem_in = rem_ff;
      nq_in  = nq_ff;
      den_in = den_ff;
      if (load) begin
         rem_in = '0;
         nq_in  = numerator;
         den_in = denominator;
      end else if (step) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         nq_in  = {nq_ff[NUM_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      nq_ff  <= nq_in;
      den_ff <= den_in;
   end

   assign quotient = nq_ff[BASE_W-1:0];

endmodule

// File: src/stfc_dp.sv
module stfc_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  stfc_pkg::stfc_cmd_type              cmd,
   output stfc_pkg::stfc_status_type           status,
   input  logic [stfc_pkg::ELAPSED_W-1:0]      req_elapsed_ms,
   input  logic [stfc_pkg::SPEED_W-1:0]        req_speed_reading,
   input  logic [stfc_pkg::TDS_W-1:0]          req_tds_ppm,
   input  logic [stfc_pkg::TURB_W-1:0]         req_turbidity_ntu,
   input  logic [stfc_pkg::DIST_W-1:0]         req_distance_mm,
   input  logic                                req_distance_valid,
   input  logic                                csr_write,
   input  logic [stfc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [stfc_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [stfc_pkg::HOUR_W-1:0]         rsp_clock_hour,
   output logic [stfc_pkg::MINUTE_W-1:0]       rsp_clock_minute,
   output logic                                rsp_water_dirty,
   output logic                                rsp_fill_active,
   output logic                                rsp_pump_on,
   output logic                                rsp_hold_active,
   output logic                                rsp_due_message
);
   import stfc_pkg::*;

   function automatic logic [TIMER_BITS-1:0] sat_add(input logic [TIMER_BITS-1:0] a,
                                                     input logic [ELAPSED_W-1:0] b);
      logic [ACC_W-1:0] s;
      s = ACC_W'(a) + ACC_W'(b);
      return (s > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0] : s[TIMER_BITS-1:0];
   endfunction

   // configuration
   logic [DIST_W-1:0] low_level_ff, high_level_ff;
   logic [TDS_W-1:0]  tds_limit_ff;
   logic [TURB_W-1:0] turb_limit_ff;
   logic [MOD_W-1:0]  first_fill_ff, second_fill_ff;
   logic [HOLD_W-1:0] hold_time_ff;
   logic [BASE_W-1:0] base_minute_ff;

   // captured item
   logic [ELAPSED_W-1:0] in_elapsed_ff;
   logic [TDS_W-1:0]     in_tds_ff;
   logic [TURB_W-1:0]    in_turb_ff;
   logic [DIST_W-1:0]    in_dist_ff;
   logic                 in_dvalid_ff;

   // controller state
   logic [HOUR_W-1:0]     hour_ff, hour_in;
   logic [MINUTE_W-1:0]   minute_ff, minute_in;
   logic [TIMER_BITS-1:0] min_el_ff, min_el_in;
   logic [TIMER_BITS-1:0] hold_el_ff, hold_el_in;
   logic [TIMER_BITS-1:0] due_el_ff, due_el_in;
   logic fired_ff, fired_in, pend_ff, pend_in, pump_ff, pump_in;
   logic hold_ff, hold_in, due_ff, due_in, dirty_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [HOUR_W-1:0]   rsp_hour_ff;
   logic [MINUTE_W-1:0] rsp_minute_ff;
   logic rsp_dirty_ff, rsp_fill_ff, rsp_pump_ff, rsp_hold_ff, rsp_due_ff;

   logic [NUM_W-1:0]  numerator;
   logic [DEN_W-1:0]  denominator;
   logic [BASE_W-1:0] quotient;
   logic [BASE_W-1:0] interval;
   logic [MOD_W-1:0]  mod;
   logic              dist_ok;

   assign numerator   = NUM_W'({base_minute_ff, {SCALE_SHIFT{1'b0}}}) - NUM_W'(base_minute_ff);
   assign denominator = DEN_W'(SPEED_SCALE) + DEN_W'(SPEED_SLOPE) * DEN_W'(req_speed_reading);

   stfc_div u_div (
      .clock       (clock),
      .load        (cmd.capture),
      .step        (cmd.div_step),
      .numerator   (numerator),
      .denominator (denominator),
      .quotient    (quotient)
   );

   always_comb begin
      min_el_in  = sat_add(min_el_ff, in_elapsed_ff);
      hold_el_in = sat_add(hold_el_ff, in_elapsed_ff);
      due_el_in  = sat_add(due_el_ff, in_elapsed_ff);
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      fired_in   = fired_ff;
      pend_in    = pend_ff;
      pump_in    = pump_ff;
      hold_in    = hold_ff;
      due_in     = due_ff;

      // scaled clock
      interval = (quotient < BASE_W'(MIN_INTERVAL)) ? BASE_W'(MIN_INTERVAL) : quotient;
      if (ACC_W'(min_el_in) >= ACC_W'(interval)) begin
         min_el_in = '0;
         if (minute_ff == LAST_MINUTE) begin
            minute_in = '0;
            hour_in   = (hour_ff == LAST_HOUR) ? '0 : hour_ff + HOUR_W'(1);
         end else begin
            minute_in = minute_ff + MINUTE_W'(1);
         end
      end

      // schedule
      mod = MOD_W'(hour_in) * MOD_W'(MINUTES_PER_HOUR) + MOD_W'(minute_in);
      if (mod == first_fill_ff || mod == second_fill_ff) begin
         if (!fired_ff) begin
            pend_in    = 1'b1;
            hold_in    = 1'b1;
            hold_el_in = '0;
            due_in     = 1'b1;
            due_el_in  = '0;
            fired_in   = 1'b1;
         end
      end else begin
         fired_in = 1'b0;
      end

      dirty_in = (in_tds_ff > tds_limit_ff) || (in_turb_ff > turb_limit_ff);
      dist_ok  = pend_in && in_dvalid_ff;

      // pump hysteresis
      if (!pend_in || dirty_in || !dist_ok) begin
         pump_in = 1'b0;
      end else if (in_dist_ff > low_level_ff && !pump_in) begin
         pump_in = 1'b1;
      end else if (in_dist_ff < high_level_ff && pump_in) begin
         pump_in = 1'b0;
      end

      // hold expiry
      if (hold_in && ACC_W'(hold_el_in) > ACC_W'(hold_time_ff)) begin
         hold_in = 1'b0;
         if (!dist_ok || dirty_in || !pump_in) begin
            pend_in = 1'b0;
         end
      end

      // level in band
      if (pend_in && !pump_in && dist_ok &&
          in_dist_ff >= high_level_ff && in_dist_ff <= low_level_ff) begin
         pend_in = 1'b0;
         hold_in = 1'b0;
      end

      if (due_in && ACC_W'(due_el_in) >= ACC_W'(hold_time_ff)) begin
         due_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_level_ff   <= LOW_LEVEL_RST;
         high_level_ff  <= HIGH_LEVEL_RST;
         tds_limit_ff   <= TDS_LIMIT_RST;
         turb_limit_ff  <= TURB_LIMIT_RST;
         first_fill_ff  <= FIRST_FILL_RST;
         second_fill_ff <= SECOND_FILL_RST;
         hold_time_ff   <= HOLD_TIME_RST;
         base_minute_ff <= BASE_MINUTE_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LOW_LEVEL:   low_level_ff   <= csr_data[DIST_W-1:0];
            CSR_HIGH_LEVEL:  high_level_ff  <= csr_data[DIST_W-1:0];
            CSR_TDS_LIMIT:   tds_limit_ff   <= csr_data[TDS_W-1:0];
            CSR_TURB_LIMIT:  turb_limit_ff  <= csr_data[TURB_W-1:0];
            CSR_FIRST_FILL:  first_fill_ff  <= csr_data[MOD_W-1:0];
            CSR_SECOND_FILL: second_fill_ff <= csr_data[MOD_W-1:0];
            CSR_HOLD_TIME:   hold_time_ff   <= csr_data[HOLD_W-1:0];
            CSR_BASE_MINUTE: base_minute_ff <= csr_data[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_elapsed_ff <= req_elapsed_ms;
         in_tds_ff     <= req_tds_ppm;
         in_turb_ff    <= req_turbidity_ntu;
         in_dist_ff    <= req_distance_mm;
         in_dvalid_ff  <= req_distance_valid;
      end
      if (cmd.commit) begin
         rsp_hour_ff   <= hour_in;
         rsp_minute_ff <= minute_in;
         rsp_dirty_ff  <= dirty_in;
         rsp_fill_ff   <= pend_in;
         rsp_pump_ff   <= pump_in;
         rsp_hold_ff   <= hold_in;
         rsp_due_ff    <= due_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff      <= HOUR_RST;
         minute_ff    <= MINUTE_RST;
         min_el_ff    <= '0;
         hold_el_ff   <= '0;
         due_el_ff    <= '0;
         fired_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         pump_ff      <= 1'b0;
         hold_ff      <= 1'b0;
         due_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            hour_ff    <= hour_in;
            minute_ff  <= minute_in;
            min_el_ff  <= min_el_in;
            hold_el_ff <= hold_el_in;
            due_el_ff  <= due_el_in;
            fired_ff   <= fired_in;
            pend_ff    <= pend_in;
            pump_ff    <= pump_in;
            hold_ff    <= hold_in;
            due_ff     <= due_in;
         end
      end
   end

   assign status.rsp_busy  = rsp_valid_ff && rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_clock_hour   = rsp_hour_ff;
   assign rsp_clock_minute = rsp_minute_ff;
   assign rsp_water_dirty  = rsp_dirty_ff;
   assign rsp_fill_active  = rsp_fill_ff;
   assign rsp_pump_on      = rsp_pump_ff;
   assign rsp_hold_active  = rsp_hold_ff;
   assign rsp_due_message  = rsp_due_ff;

endmodule

// File: src/stfc_ctrl.sv
module stfc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  stfc_pkg::stfc_status_type  status,
   output stfc_pkg::stfc_cmd_type     cmd
);
   import stfc_pkg::*;

   stfc_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd.capture  = 1'b0;
      cmd.div_step = 1'b0;
      cmd.commit   = 1'b0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               step_in     = '0;
               state_in    = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // hold the result until the output register is free
            if (!status.rsp_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// File: test/scheduled_tank_fill_controller_checker.sv
`timescale 1ns / 100ps

module scheduled_tank_fill_controller_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [stfc_pkg::ELAPSED_W-1:0]  req_elapsed_ms,
   input  logic [stfc_pkg::SPEED_W-1:0]    req_speed_reading,
   input  logic [stfc_pkg::TDS_W-1:0]      req_tds_ppm,
   input  logic [stfc_pkg::TURB_W-1:0]     req_turbidity_ntu,
   input  logic [stfc_pkg::DIST_W-1:0]     req_distance_mm,
   input  logic                            req_distance_valid,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [stfc_pkg::HOUR_W-1:0]     rsp_clock_hour,
   input  logic [stfc_pkg::MINUTE_W-1:0]   rsp_clock_minute,
   input  logic                            rsp_water_dirty,
   input  logic                            rsp_fill_active,
   input  logic                            rsp_pump_on,
   input  logic                            rsp_hold_active,
   input  logic                            rsp_due_message,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [stfc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [stfc_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              mismatch_count,
   output int                              pending_count
);
   import stfc_pkg::*;

   localparam longint unsigned TIMER_MAX_MS = (64'd1 << TIMER_BITS) - 64'd1;

   typedef struct packed {
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic                dirty;
      logic                filling;
      logic                pump;
      logic                hold;
      logic                due;
   } tank_status_type;

   tank_status_type pending_status[$];
   tank_status_type want;
   int errors = 0;

   logic [DIST_W-1:0]   low_level_mm;
   logic [DIST_W-1:0]   high_level_mm;
   logic [TDS_W-1:0]    tds_limit_ppm;
   logic [TURB_W-1:0]   turb_limit_ntu;
   logic [MOD_W-1:0]    first_fill_at;
   logic [MOD_W-1:0]    second_fill_at;
   logic [HOLD_W-1:0]   hold_ms;
   logic [BASE_W-1:0]   base_ms;

   logic [HOUR_W-1:0]   hour_now;
   logic [MINUTE_W-1:0] minute_now;
   int unsigned         minute_ms;
   int unsigned         hold_elapsed_ms;
   int unsigned         due_elapsed_ms;
   logic                fired;
   logic                filling;
   logic                pumping;
   logic                holding;
   logic                due_shown;

   task automatic restore_defaults();
      low_level_mm    = LOW_LEVEL_RST;
      high_level_mm   = HIGH_LEVEL_RST;
      tds_limit_ppm   = TDS_LIMIT_RST;
      turb_limit_ntu  = TURB_LIMIT_RST;
      first_fill_at   = FIRST_FILL_RST;
      second_fill_at  = SECOND_FILL_RST;
      hold_ms         = HOLD_TIME_RST;
      base_ms         = BASE_MINUTE_RST;
      hour_now        = HOUR_RST;
      minute_now      = MINUTE_RST;
      minute_ms       = 0;
      hold_elapsed_ms = 0;
      due_elapsed_ms  = 0;
      fired           = 1'b0;
      filling         = 1'b0;
      pumping         = 1'b0;
      holding         = 1'b0;
      due_shown       = 1'b0;
   endtask

   function automatic int unsigned sat_sum(input int unsigned acc,
                                           input logic [ELAPSED_W-1:0] add);
      longint unsigned total;
      total = 64'(acc) + 64'(add);
      return (total > TIMER_MAX_MS) ? int'(TIMER_MAX_MS) : int'(total);
   endfunction

   task automatic step_controller(input logic [ELAPSED_W-1:0] elapsed,
                                  input logic [SPEED_W-1:0] speed,
                                  input logic [TDS_W-1:0] tds,
                                  input logic [TURB_W-1:0] turb,
                                  input logic [DIST_W-1:0] distance,
                                  input logic dist_valid);
      longint unsigned interval;
      int unsigned tod;
      logic dirty;
      logic dist_used;
      tank_status_type s;

      minute_ms       = sat_sum(minute_ms, elapsed);
      hold_elapsed_ms = sat_sum(hold_elapsed_ms, elapsed);
      due_elapsed_ms  = sat_sum(due_elapsed_ms, elapsed);

      // scaled minute clock
      interval = (64'(base_ms) * 64'(SPEED_SCALE)) /
                 (64'(SPEED_SCALE) + 64'(SPEED_SLOPE) * 64'(speed));
      if (interval < MIN_INTERVAL) interval = MIN_INTERVAL;
      if (64'(minute_ms) >= interval) begin
         minute_ms = 0;
         if (minute_now == LAST_MINUTE) begin
            minute_now = '0;
            hour_now = (hour_now == LAST_HOUR) ? '0 : hour_now + 1'b1;
         end else begin
            minute_now = minute_now + 1'b1;
         end
      end

      // schedule, once per matching minute
      tod = hour_now * MINUTES_PER_HOUR + minute_now;
      if (tod == first_fill_at || tod == second_fill_at) begin
         if (!fired) begin
            filling         = 1'b1;
            holding         = 1'b1;
            hold_elapsed_ms = 0;
            due_shown       = 1'b1;
            due_elapsed_ms  = 0;
            fired           = 1'b1;
         end
      end else begin
         fired = 1'b0;
      end

      dirty     = (tds > tds_limit_ppm) || (turb > turb_limit_ntu);
      dist_used = filling && dist_valid;

      // pump hysteresis
      if (!filling || dirty || !dist_used) begin
         pumping = 1'b0;
      end else if (distance > low_level_mm && !pumping) begin
         pumping = 1'b1;
      end else if (distance < high_level_mm && pumping) begin
         pumping = 1'b0;
      end

      if (holding && hold_elapsed_ms > hold_ms) begin
         holding = 1'b0;
         if (!dist_used || dirty || !pumping) filling = 1'b0;
      end

      // level inside the band
      if (filling && !pumping && dist_used &&
          distance >= high_level_mm && distance <= low_level_mm) begin
         filling = 1'b0;
         holding = 1'b0;
      end

      if (due_shown && due_elapsed_ms >= hold_ms) due_shown = 1'b0;

      s.hour    = hour_now;
      s.minute  = minute_now;
      s.dirty   = dirty;
      s.filling = filling;
      s.pump    = pumping;
      s.hold    = holding;
      s.due     = due_shown;
      pending_status.push_back(s);
   endtask

   task automatic check_field(input string name, input int unsigned expected_value,
                              input int unsigned actual_value);
      if (expected_value != actual_value) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, name, expected_value, actual_value);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restore_defaults();
         pending_status.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_status.size() == 0) begin
               $display("%0t: rsp beat with no control cycle outstanding", $time);
               errors++;
            end else begin
               want = pending_status.pop_front();
               check_field("clock_hour", want.hour, rsp_clock_hour);
               check_field("clock_minute", want.minute, rsp_clock_minute);
               check_field("water_dirty", want.dirty, rsp_water_dirty);
               check_field("fill_active", want.filling, rsp_fill_active);
               check_field("pump_on", want.pump, rsp_pump_on);
               check_field("hold_active", want.hold, rsp_hold_active);
               check_field("due_message", want.due, rsp_due_message);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LOW_LEVEL:   low_level_mm   = csr_data[DIST_W-1:0];
               CSR_HIGH_LEVEL:  high_level_mm  = csr_data[DIST_W-1:0];
               CSR_TDS_LIMIT:   tds_limit_ppm  = csr_data[TDS_W-1:0];
               CSR_TURB_LIMIT:  turb_limit_ntu = csr_data[TURB_W-1:0];
               CSR_FIRST_FILL:  first_fill_at  = csr_data[MOD_W-1:0];
               CSR_SECOND_FILL: second_fill_at = csr_data[MOD_W-1:0];
               CSR_HOLD_TIME:   hold_ms        = csr_data[HOLD_W-1:0];
               CSR_BASE_MINUTE: base_ms        = csr_data[BASE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            step_controller(req_elapsed_ms, req_speed_reading, req_tds_ppm,
                            req_turbidity_ntu, req_distance_mm, req_distance_valid);
         end
      end
      mismatch_count <= errors;
      pending_count <= pending_status.size();
   end

endmodule

// File: test/scheduled_tank_fill_controller_test.sv
`timescale 1ns / 100ps

module scheduled_tank_fill_controller_test;
   import stfc_pkg::*;

   localparam int CYCLE_LIMIT     = 600000;
   localparam int RANDOM_PHASES   = 20;
   localparam int ITEMS_PER_PHASE = 47;
   localparam int DRAIN_CYCLES    = 64;
   localparam int MINUTES_PER_DAY = 1440;
   localparam int MAX_DISTANCE_MM = 5000;
   localparam int MAX_TDS_PPM     = 2000;
   localparam int MAX_TURB_NTU    = 1000;
   localparam logic [CSR_IDX_W-1:0]  CSR_FIRST_UNUSED = CSR_IDX_W'(8);
   localparam logic [CSR_DATA_W-1:0] ALL_ONES = '1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [ELAPSED_W-1:0]  req_elapsed_ms = '0;
   logic [SPEED_W-1:0]    req_speed_reading = '0;
   logic [TDS_W-1:0]      req_tds_ppm = '0;
   logic [TURB_W-1:0]     req_turbidity_ntu = '0;
   logic [DIST_W-1:0]     req_distance_mm = '0;
   logic                  req_distance_valid = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [HOUR_W-1:0]     rsp_clock_hour;
   logic [MINUTE_W-1:0]   rsp_clock_minute;
   logic                  rsp_water_dirty;
   logic                  rsp_fill_active;
   logic                  rsp_pump_on;
   logic                  rsp_hold_active;
   logic                  rsp_due_message;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int mismatch_count;
   int pending_count;
   int cycle_count = 0;
   int burst_left = 0;
   logic [HOUR_W-1:0]   shown_hour = HOUR_RST;
   logic [MINUTE_W-1:0] shown_minute = MINUTE_RST;

   always #5 clock = ~clock;

   scheduled_tank_fill_controller i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_elapsed_ms     (req_elapsed_ms),
      .req_speed_reading  (req_speed_reading),
      .req_tds_ppm        (req_tds_ppm),
      .req_turbidity_ntu  (req_turbidity_ntu),
      .req_distance_mm    (req_distance_mm),
      .req_distance_valid (req_distance_valid),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_clock_hour     (rsp_clock_hour),
      .rsp_clock_minute   (rsp_clock_minute),
      .rsp_water_dirty    (rsp_water_dirty),
      .rsp_fill_active    (rsp_fill_active),
      .rsp_pump_on        (rsp_pump_on),
      .rsp_hold_active    (rsp_hold_active),
      .rsp_due_message    (rsp_due_message),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   scheduled_tank_fill_controller_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_elapsed_ms     (req_elapsed_ms),
      .req_speed_reading  (req_speed_reading),
      .req_tds_ppm        (req_tds_ppm),
      .req_turbidity_ntu  (req_turbidity_ntu),
      .req_distance_mm    (req_distance_mm),
      .req_distance_valid (req_distance_valid),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_clock_hour     (rsp_clock_hour),
      .rsp_clock_minute   (rsp_clock_minute),
      .rsp_water_dirty    (rsp_water_dirty),
      .rsp_fill_active    (rsp_fill_active),
      .rsp_pump_on        (rsp_pump_on),
      .rsp_hold_active    (rsp_hold_active),
      .rsp_due_message    (rsp_due_message),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // last clock reading seen on the rsp side, used to aim the fill minutes
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         shown_hour <= rsp_clock_hour;
         shown_minute <= rsp_clock_minute;
      end
   end

   // receiver stall pattern, with a long hold-off every eighth segment
   initial begin
      int unsigned run_len;
      int unsigned stall_pct;
      int unsigned seg;
      seg = 0;
      forever begin
         seg++;
         if (seg % 8 == 3) begin
            run_len = $urandom_range(200, 400);
            stall_pct = 100;
         end else begin
            run_len = $urandom_range(20, 150);
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 30;
               default: stall_pct = 75;
            endcase
         end
         repeat (run_len) begin
            @(posedge clock);
            rsp_stall <= ($urandom_range(1, 100) <= stall_pct);
         end
      end
   end

   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
   endtask

   task automatic send_item(input logic [ELAPSED_W-1:0] elapsed,
                            input logic [SPEED_W-1:0] speed,
                            input logic [TDS_W-1:0] tds,
                            input logic [TURB_W-1:0] turb,
                            input logic [DIST_W-1:0] distance,
                            input logic dist_valid);
      pace_sender();
      req_valid          <= 1'b1;
      req_elapsed_ms     <= elapsed;
      req_speed_reading  <= speed;
      req_tds_ppm        <= tds;
      req_turbidity_ntu  <= turb;
      req_distance_mm    <= distance;
      req_distance_valid <= dist_valid;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random_item();
      logic [ELAPSED_W-1:0] elapsed;
      logic [SPEED_W-1:0]   speed;
      logic [TDS_W-1:0]     tds;
      logic [TURB_W-1:0]    turb;
      logic [DIST_W-1:0]    distance;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) elapsed = ELAPSED_W'($urandom_range(0, 400));
      else if (pick < 80) elapsed = ELAPSED_W'($urandom_range(0, 3000));
      else if (pick < 90) elapsed = '0;
      else elapsed = ELAPSED_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 50) speed = SPEED_W'($urandom);
      else if (pick < 75) speed = '0;
      else speed = '1;
      tds = ($urandom_range(0, 9) < 8) ? TDS_W'($urandom_range(0, 250))
                                       : TDS_W'($urandom_range(0, MAX_TDS_PPM));
      turb = ($urandom_range(0, 9) < 8) ? TURB_W'($urandom_range(0, 250))
                                        : TURB_W'($urandom_range(0, MAX_TURB_NTU));
      pick = $urandom_range(0, 99);
      if (pick < 50) distance = DIST_W'($urandom_range(0, 700));
      else if (pick < 80) distance = DIST_W'($urandom_range(0, MAX_DISTANCE_MM));
      else distance = DIST_W'($urandom_range(50, 300));
      send_item(elapsed, speed, tds, turb, distance, $urandom_range(0, 9) != 0);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic configure_phase(input int phase);
      int now;
      int pick;
      logic [CSR_DATA_W-1:0] low_mm, high_mm, tds_lim, turb_lim;
      logic [CSR_DATA_W-1:0] first_at, second_at, hold_len, base_len;
      now = shown_hour * MINUTES_PER_HOUR + shown_minute;
      first_at  = CSR_DATA_W'((now + $urandom_range(0, 3)) % MINUTES_PER_DAY);
      second_at = CSR_DATA_W'((now + $urandom_range(2, 8)) % MINUTES_PER_DAY);
      low_mm    = CSR_DATA_W'($urandom_range(150, 600));
      high_mm   = CSR_DATA_W'($urandom_range(40, 200));
      tds_lim   = CSR_DATA_W'($urandom_range(600, MAX_TDS_PPM));
      turb_lim  = CSR_DATA_W'($urandom_range(300, MAX_TURB_NTU));
      pick = $urandom_range(0, 9);
      if (pick == 0) hold_len = '0;
      else if (pick == 1) hold_len = ALL_ONES;
      else hold_len = CSR_DATA_W'($urandom_range(0, 3000));
      pick = $urandom_range(0, 9);
      if (pick == 0) base_len = CSR_DATA_W'($urandom_range(0, MIN_INTERVAL - 1));
      else if (pick == 1) base_len = ALL_ONES;
      else base_len = CSR_DATA_W'($urandom_range(MIN_INTERVAL, 1500));
      case (phase)
         0: begin
            low_mm   = '0;
            high_mm  = '0;
            tds_lim  = '0;
            turb_lim = '0;
            hold_len = '0;
            base_len = '0;
         end
         1: begin
            low_mm    = ALL_ONES;
            high_mm   = ALL_ONES;
            tds_lim   = ALL_ONES;
            turb_lim  = ALL_ONES;
            first_at  = ALL_ONES;
            second_at = ALL_ONES;
            hold_len  = ALL_ONES;
            base_len  = ALL_ONES;
         end
         2: begin
            low_mm    = CSR_DATA_W'(MAX_DISTANCE_MM);
            high_mm   = '0;
            tds_lim   = CSR_DATA_W'(MAX_TDS_PPM);
            turb_lim  = CSR_DATA_W'(MAX_TURB_NTU);
            first_at  = '0;
            second_at = CSR_DATA_W'(MINUTES_PER_DAY - 1);
            hold_len  = ALL_ONES;
            base_len  = CSR_DATA_W'(MIN_INTERVAL - 1);
         end
         default: ;
      endcase
      write_register(CSR_LOW_LEVEL, low_mm);
      write_register(CSR_HIGH_LEVEL, high_mm);
      write_register(CSR_TDS_LIMIT, tds_lim);
      write_register(CSR_TURB_LIMIT, turb_lim);
      write_register(CSR_FIRST_FILL, first_at);
      write_register(CSR_SECOND_FILL, second_at);
      write_register(CSR_HOLD_TIME, hold_len);
      write_register(CSR_BASE_MINUTE, base_len);
      write_register(CSR_FIRST_UNUSED + CSR_IDX_W'($urandom_range(0, 7)),
                     CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: walk into the first fill and through the pump states
      send_item('0, '0, '0, '0, '0, 1'b0);
      send_item('1, '1, TDS_W'(MAX_TDS_PPM), TURB_W'(MAX_TURB_NTU),
                DIST_W'(MAX_DISTANCE_MM), 1'b1);
      send_item(ELAPSED_W'(1000), '0, TDS_LIMIT_RST, TURB_LIMIT_RST, DIST_W'(300), 1'b1);
      send_item(ELAPSED_W'(100), SPEED_W'(2048), '0, '0, DIST_W'(251), 1'b1);
      send_item(ELAPSED_W'(100), '0, '0, '0, DIST_W'(99), 1'b1);
      send_item(ELAPSED_W'(100), '0, TDS_LIMIT_RST + 1'b1, '0, DIST_W'(300), 1'b1);
      send_item(ELAPSED_W'(100), '0, '0, TURB_LIMIT_RST + 1'b1, DIST_W'(300), 1'b1);
      send_item(ELAPSED_W'(100), '0, '0, '0, DIST_W'(300), 1'b0);
      send_item(ELAPSED_W'(100), '0, '0, '0, DIST_W'(300), 1'b1);
      send_item(ELAPSED_W'(2000), '0, '0, '0, DIST_W'(180), 1'b1);
      send_item(ELAPSED_W'(100), '0, '0, '0, DIST_W'(90), 1'b1);
      send_item(ELAPSED_W'(100), '0, '0, '0, DIST_W'(180), 1'b1);
      send_item(ELAPSED_W'(21845), SPEED_W'(1365), TDS_W'(1365), TURB_W'(682),
                DIST_W'(2730), 1'b1);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         configure_phase(p);
         repeat (ITEMS_PER_PHASE) send_random_item();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
